// ----- hdl/iafq_pkg.sv -----
// Package of shared types and constants for the ID allocator with its queue of idle IDs.
package iafq_pkg;

    localparam int POOL_SIZE = 1024;
    localparam int PTR_W     = $clog2(POOL_SIZE);
    localparam int CNT_W     = PTR_W + 1;
    localparam int ID_W      = 16;
    localparam int FRESH_W   = ID_W + 1;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [ID_W-1:0] FIRST_ID_RESET = 16'd3000;
    localparam logic [ID_W-1:0] LAST_ID_RESET  = 16'd3999;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC     = 2'd0,
        CMD_FREE      = 2'd1,
        CMD_SET_TOOL  = 2'd2,
        CMD_CLEAR_ALL = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_ID = 1'd0,
        REG_LAST_ID  = 1'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

// ----- hdl/id_allocator_free_queue.sv -----
// ID allocator: hands out IDs from a range, reusing freed IDs in order before fresh ones.
// A result is registered in ST_EXEC, the state entered once its input beat is accepted.
// A new request is taken only in ST_IDLE, after the read of the idle-mark and queue memories
// and their write-back for the last request; a stalled result also holds new requests.
// Reset (asynchronous, rst_n low) restores the range registers and empties the queue;
// no clearing pass is needed, as each mark is zeroed when its ID is first issued.
module id_allocator_free_queue
    import iafq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [ID_W-1:0]      id,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ID_W-1:0]      id_out,
    output logic                 ok,
    output logic [ID_W-1:0]      tool_id,
    output logic                 tool_valid,
    // configuration channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ID_W-1:0]      cfg_data
);

    // Memories
    logic [ID_W-1:0] fifo_mem [POOL_SIZE];
    logic            mark_mem [POOL_SIZE];

    state_t              state_reg, state_next;
    logic [ID_W-1:0]     first_id_reg, first_id_next;
    logic [ID_W-1:0]     last_id_reg, last_id_next;
    logic [FRESH_W-1:0]  next_fresh_reg, next_fresh_next;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ID_W-1:0]     tool_reg, tool_next;
    logic                tool_flag_reg, tool_flag_next;
    logic                out_valid_reg, out_valid_next;
    logic [ID_W-1:0]     id_out_reg, id_out_next;
    logic                ok_reg, ok_next;

    cmd_t                cmd_reg;
    logic [ID_W-1:0]     id_reg;
    logic [ID_W-1:0]     fifo_rd_reg;
    logic                mark_rd_reg;

    logic                in_accept;
    logic                cfg_write;
    logic [ID_W-1:0]     in_offset;
    logic [FRESH_W-1:0]  cap;
    logic [FRESH_W-1:0]  top;
    logic                free_in_range;

    logic                mark_we;
    logic [PTR_W-1:0]    mark_waddr;
    logic                mark_wdata;
    logic                fifo_we;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && (!out_valid_reg || !out_stall));
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_offset = id - first_id_reg;

    // The usable top of the range never exceeds the pool; last_id already caps it at 16 bits.
    assign cap = {1'b0, first_id_reg} + FRESH_W'(POOL_SIZE - 1);
    assign top = ({1'b0, last_id_reg} < cap) ? {1'b0, last_id_reg} : cap;

    assign free_in_range = (id_reg >= first_id_reg) && ({1'b0, id_reg} <= top)
                           && ({1'b0, id_reg} < next_fresh_reg);

    always_comb
    begin
        state_next      = state_reg;
        first_id_next   = first_id_reg;
        last_id_next    = last_id_reg;
        next_fresh_next = next_fresh_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        tool_next       = tool_reg;
        tool_flag_next  = tool_flag_reg;
        out_valid_next  = out_valid_reg && out_stall;
        id_out_next     = id_out_reg;
        ok_next         = ok_reg;
        mark_we         = 1'b0;
        mark_waddr      = in_offset[PTR_W-1:0];
        mark_wdata      = 1'b0;
        fifo_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                id_out_next    = '0;
                ok_next        = 1'b0;
                case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (count_reg != '0)
                        begin
                            id_out_next = fifo_rd_reg;
                            ok_next     = 1'b1;
                            head_next   = head_reg + PTR_W'(1);
                            count_next  = count_reg - CNT_W'(1);
                            mark_we     = 1'b1;
                            mark_waddr  = PTR_W'(fifo_rd_reg - first_id_reg);
                        end
                        else if (next_fresh_reg <= top)
                        begin
                            // Issuing a fresh ID zeroes its mark, so marks above the
                            // fresh counter never need clearing.
                            id_out_next     = next_fresh_reg[ID_W-1:0];
                            ok_next         = 1'b1;
                            next_fresh_next = next_fresh_reg + FRESH_W'(1);
                            mark_we         = 1'b1;
                            mark_waddr      = PTR_W'(next_fresh_reg[ID_W-1:0] - first_id_reg);
                        end
                    end
                    CMD_FREE:
                    begin
                        if (tool_flag_reg && (id_reg == tool_reg))
                        begin
                            tool_flag_next = 1'b0;
                            tool_next      = '0;
                        end
                        if (free_in_range && !mark_rd_reg
                            && (count_reg < CNT_W'(POOL_SIZE)))
                        begin
                            mark_we    = 1'b1;
                            mark_waddr = PTR_W'(id_reg - first_id_reg);
                            mark_wdata = 1'b1;
                            fifo_we    = 1'b1;
                            tail_next  = tail_reg + PTR_W'(1);
                            count_next = count_reg + CNT_W'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    CMD_SET_TOOL:
                    begin
                        tool_next      = id_reg;
                        tool_flag_next = 1'b1;
                    end
                    default:
                    begin
                        next_fresh_next = {1'b0, first_id_reg};
                        head_next       = '0;
                        tail_next       = '0;
                        count_next      = '0;
                        tool_next       = '0;
                        tool_flag_next  = 1'b0;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A register write also empties the allocator for the new range.
        if (cfg_write)
        begin
            case (cfg_index)
                REG_FIRST_ID:
                begin
                    first_id_next = cfg_data;
                end
                REG_LAST_ID:
                begin
                    last_id_next = cfg_data;
                end
                default:
                begin
                    last_id_next = last_id_reg;
                end
            endcase
            next_fresh_next = {1'b0, first_id_next};
            head_next       = '0;
            tail_next       = '0;
            count_next      = '0;
            tool_next       = '0;
            tool_flag_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_id_reg   <= FIRST_ID_RESET;
            last_id_reg    <= LAST_ID_RESET;
            next_fresh_reg <= {1'b0, FIRST_ID_RESET};
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            tool_reg       <= '0;
            tool_flag_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_id_reg   <= first_id_next;
            last_id_reg    <= last_id_next;
            next_fresh_reg <= next_fresh_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            tool_reg       <= tool_next;
            tool_flag_reg  <= tool_flag_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers of the accepted beat and of the result.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg <= cmd_t'(cmd);
            id_reg  <= id;
        end
        id_out_reg <= id_out_next;
        ok_reg     <= ok_next;
    end

    // Both memories are read when a beat is accepted and written back in the
    // following cycle; the next read can come only after that write-back, so no forwarding.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            fifo_rd_reg <= fifo_mem[head_reg];
            mark_rd_reg <= mark_mem[in_offset[PTR_W-1:0]];
        end
        if (fifo_we)
        begin
            fifo_mem[tail_reg] <= id_reg;
        end
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
    end

    assign out_valid  = out_valid_reg;
    assign id_out     = id_out_reg;
    assign ok         = ok_reg;
    assign tool_id    = tool_reg;
    assign tool_valid = tool_flag_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(POOL_SIZE))
        else $error("idle queue count exceeds the pool size");

    a_count_pointers: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[PTR_W-1:0] == PTR_W'(tail_reg - head_reg))
        else $error("idle queue count disagrees with its pointers");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> ##2 out_valid_reg)
        else $error("accepted beat produced no result");

    a_fail_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !ok_reg) |-> (id_out_reg == '0))
        else $error("failed or non-allocating result carries a nonzero ID");

    a_tool_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        !tool_flag_reg |-> (tool_reg == '0))
        else $error("tool ID held without its flag");
`endif

endmodule
